FILE: rtl/parking_bay_and_gate_controller_macros.svh
// ----------------------------------------------------------------------------
// Parking bay and gate controller assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PARKING_BAY_AND_GATE_CONTROLLER_MACROS_SVH
`define PARKING_BAY_AND_GATE_CONTROLLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PBGC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PBGC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/pbgc_pkg.sv
// ----------------------------------------------------------------------------
// Parking bay and gate controller package
// Field widths, output codes, register indexes, reset values and lane types.
// ----------------------------------------------------------------------------
`default_nettype none

package pbgc_pkg;

  // Field widths.
  localparam int ECHO_W  = 15;
  localparam int TIME_W  = 32;
  localparam int PRESS_W = 16;
  localparam int SECS_W  = 23;
  localparam int CIDX_W  = 3;

  // Bay light codes.
  localparam logic [1:0] LIGHT_GREEN  = 2'd0;
  localparam logic [1:0] LIGHT_RED    = 2'd1;
  localparam logic [1:0] LIGHT_YELLOW = 2'd2;

  // Gate state codes.
  localparam logic [2:0] GS_CLOSED     = 3'd0;
  localparam logic [2:0] GS_OPEN_ENTRY = 3'd1;
  localparam logic [2:0] GS_OPEN_EXIT  = 3'd2;
  localparam logic [2:0] GS_HOLD       = 3'd3;
  localparam logic [2:0] GS_LOCKED     = 3'd4;

  // Alert codes.
  localparam logic [2:0] AL_NONE      = 3'd0;
  localparam logic [2:0] AL_REFUSED   = 3'd1;
  localparam logic [2:0] AL_BOTH_OVER = 3'd2;
  localparam logic [2:0] AL_BAY1_OVER = 3'd3;
  localparam logic [2:0] AL_BAY2_OVER = 3'd4;
  localparam logic [2:0] AL_FULL      = 3'd5;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_NEAR_ECHO  = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_OVERSTAY   = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_THRESHOLD  = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_DEBOUNCE   = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_HOLD       = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_FLASH      = 3'd5;
  localparam logic [CIDX_W-1:0] CFG_ENTRY_BASE = 3'd6;
  localparam logic [CIDX_W-1:0] CFG_EXIT_BASE  = 3'd7;

  // Register reset values.
  localparam logic [ECHO_W-1:0]         RST_NEAR_ECHO = 15'd2320;
  localparam logic [TIME_W-1:0]         RST_OVERSTAY  = 32'd10000;
  localparam logic signed [PRESS_W-1:0] RST_THRESHOLD = 16'sd120;
  localparam logic [TIME_W-1:0]         RST_DEBOUNCE  = 32'd300;
  localparam logic [TIME_W-1:0]         RST_HOLD      = 32'd6000;
  localparam logic [TIME_W-1:0]         RST_FLASH     = 32'd200;
  localparam logic signed [PRESS_W-1:0] RST_BASELINE  = 16'sd0;

  // Milliseconds to seconds: x / 1000 = ((x >> 3) * SEC_RECIP) >> SEC_SHIFT,
  // exact for every 32-bit x.
  localparam logic [29:0] SEC_RECIP = 30'd549755814;
  localparam int          SEC_SHIFT = 36;

  // What one bay lane reports to the merging stage.
  typedef struct packed {
    logic occ;
    logic over;
  } bay_stat_t;

  // Per-item results of the merging stage, bay seconds excluded.
  typedef struct packed {
    logic [1:0] bay1_light;
    logic [1:0] bay2_light;
    logic       gate_open;
    logic       gate_led;
    logic       entry_pressed;
    logic       exit_pressed;
    logic [2:0] gate_state;
    logic [2:0] alert_code;
    logic [1:0] free_spaces;
  } merge_res_t;

endpackage

`default_nettype wire

FILE: rtl/pbgc_in_if.sv
// ----------------------------------------------------------------------------
// Sample channel
// One sample tick: six echo times, two plate pressures and the timestamp.
// ----------------------------------------------------------------------------
`default_nettype none

interface pbgc_in_if;
  logic                 valid;
  logic                 ready;
  logic [14:0]          bay1_top_echo;
  logic [14:0]          bay1_left_echo;
  logic [14:0]          bay1_right_echo;
  logic [14:0]          bay2_top_echo;
  logic [14:0]          bay2_left_echo;
  logic [14:0]          bay2_right_echo;
  logic signed [15:0]   entry_pressure;
  logic signed [15:0]   exit_pressure;
  logic [31:0]          now_ms;

  modport source (
    output valid, bay1_top_echo, bay1_left_echo, bay1_right_echo,
           bay2_top_echo, bay2_left_echo, bay2_right_echo,
           entry_pressure, exit_pressure, now_ms,
    input  ready
  );
  modport sink (
    input  valid, bay1_top_echo, bay1_left_echo, bay1_right_echo,
           bay2_top_echo, bay2_left_echo, bay2_right_echo,
           entry_pressure, exit_pressure, now_ms,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/pbgc_out_if.sv
// ----------------------------------------------------------------------------
// Status channel
// One status record per sample tick: lights, gate, alert and bay timers.
// ----------------------------------------------------------------------------
`default_nettype none

interface pbgc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  bay1_light;
  logic [1:0]  bay2_light;
  logic        gate_open;
  logic        gate_led;
  logic        entry_pressed;
  logic        exit_pressed;
  logic [2:0]  gate_state;
  logic [2:0]  alert_code;
  logic [1:0]  free_spaces;
  logic [22:0] bay1_seconds;
  logic [22:0] bay2_seconds;

  modport source (
    output valid, bay1_light, bay2_light, gate_open, gate_led, entry_pressed,
           exit_pressed, gate_state, alert_code, free_spaces,
           bay1_seconds, bay2_seconds,
    input  ready
  );
  modport sink (
    input  valid, bay1_light, bay2_light, gate_open, gate_led, entry_pressed,
           exit_pressed, gate_state, alert_code, free_spaces,
           bay1_seconds, bay2_seconds,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/pbgc_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Register index and 32-bit write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface pbgc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  idx;
  logic [31:0] data;

  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/pbgc_bay_lane.sv
// ----------------------------------------------------------------------------
// Bay lane
// Occupancy detection, occupancy timer and whole-seconds conversion for one bay.
// ----------------------------------------------------------------------------
`default_nettype none

module pbgc_bay_lane (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  load,
  input  wire logic [14:0]           top_echo,
  input  wire logic [14:0]           left_echo,
  input  wire logic [14:0]           right_echo,
  input  wire logic [14:0]           near_us,
  input  wire logic [31:0]           stay_limit,
  input  wire logic [31:0]           now_ms,
  output pbgc_pkg::bay_stat_t        stat,
  output logic [22:0]                secs
);

  logic        held_r;
  logic [31:0] since_r;
  logic [31:0] elapsed_r;
  logic        occ;
  logic [31:0] elapsed;
  logic [58:0] prod;

  // A bay is blocked when all three echoes are present and near.
  assign occ = (top_echo != '0)   && (top_echo <= near_us) &&
               (left_echo != '0)  && (left_echo <= near_us) &&
               (right_echo != '0) && (right_echo <= near_us);

  // Elapsed occupancy; a fresh occupancy starts at zero.
  assign elapsed   = held_r ? (now_ms - since_r) : '0;
  assign stat.occ  = occ;
  assign stat.over = occ && (elapsed >= stay_limit);

  // Occupancy start time.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= 1'b0;
      since_r <= '0;
    end else if (load) begin
      held_r <= occ;
      if (occ && !held_r) begin
        since_r <= now_ms;
      end
    end
  end

  // Elapsed time for the seconds stage.
  always_ff @(posedge clk) begin
    if (load) begin
      elapsed_r <= occ ? elapsed : '0;
    end
  end

  // Divide by 1000 through a reciprocal multiply.
  assign prod = 59'(elapsed_r[31:3]) * 59'(pbgc_pkg::SEC_RECIP);
  assign secs = prod[58:pbgc_pkg::SEC_SHIFT];

endmodule

`default_nettype wire

FILE: rtl/pbgc_plate_lane.sv
// ----------------------------------------------------------------------------
// Plate lane
// Baseline removal, threshold compare and debounce for one pressure plate.
// ----------------------------------------------------------------------------
`default_nettype none

module pbgc_plate_lane (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,
  input  wire logic signed [15:0] pressure,
  input  wire logic signed [15:0] baseline,
  input  wire logic signed [15:0] threshold,
  input  wire logic [31:0]        debounce_ms,
  input  wire logic [31:0]        now_ms,
  output logic                    committed
);

  logic               cand_r;
  logic [31:0]        ctime_r;
  logic               comm_r;
  logic signed [15:0] delta;
  logic               raw;
  logic               changed;
  logic               stable;

  // Pressure above baseline, wrapped to 16 bits.
  assign delta = pressure - baseline;
  assign raw   = delta > threshold;

  // A change restarts the stability timer at this tick.
  assign changed   = raw != cand_r;
  assign stable    = changed ? (debounce_ms == '0) : ((now_ms - ctime_r) >= debounce_ms);
  assign committed = stable ? raw : comm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r  <= 1'b0;
      ctime_r <= '0;
      comm_r  <= 1'b0;
    end else if (load) begin
      cand_r <= raw;
      comm_r <= committed;
      if (changed) begin
        ctime_r <= now_ms;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pbgc_gate_merge.sv
// ----------------------------------------------------------------------------
// Gate merging stage
// Combines bay and plate lanes into gate control, LED, alert and bay lights.
// ----------------------------------------------------------------------------
`default_nettype none

module pbgc_gate_merge (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                load,
  input  wire pbgc_pkg::bay_stat_t bay1,
  input  wire pbgc_pkg::bay_stat_t bay2,
  input  wire logic                entry_comm,
  input  wire logic                exit_comm,
  input  wire logic [31:0]         hold_ms,
  input  wire logic [31:0]         flash_ms,
  input  wire logic [31:0]         now_ms,
  output pbgc_pkg::merge_res_t     res_r
);

  logic        open_r, open_nxt;
  logic        obe_r, obe_nxt;
  logic        hc_r, hc_nxt;
  logic [31:0] dl_r, dl_nxt;
  logic        refl_r, refl_nxt;
  logic        led_r, led_nxt;
  logic [31:0] tog_r, tog_nxt;
  logic        full;
  logic        rel;
  logic [31:0] dl_diff;
  pbgc_pkg::merge_res_t res_nxt;

  // Gate control and LED for this tick.
  always_comb begin
    full     = bay1.occ && bay2.occ;
    open_nxt = open_r;
    obe_nxt  = obe_r;
    hc_nxt   = hc_r;
    dl_nxt   = dl_r;
    refl_nxt = refl_r;
    led_nxt  = led_r;
    tog_nxt  = tog_r;
    rel      = obe_r ? exit_comm : entry_comm;
    dl_diff  = now_ms - dl_r;

    if (!open_r) begin
      if (entry_comm) begin
        if (!full) begin
          open_nxt = 1'b1;
          obe_nxt  = 1'b0;
          hc_nxt   = 1'b0;
        end else begin
          refl_nxt = 1'b1;
        end
      end else begin
        refl_nxt = 1'b0;
        if (exit_comm) begin
          open_nxt = 1'b1;
          obe_nxt  = 1'b1;
          hc_nxt   = 1'b0;
        end
      end
    end else begin
      // Release of the opening plate starts the hold timer.
      if (!rel && !hc_r) begin
        hc_nxt  = 1'b1;
        dl_nxt  = now_ms + hold_ms;
        dl_diff = '0 - hold_ms;
      end
      // Deadline reached when the wrapped difference is non-negative.
      if (hc_nxt && !dl_diff[31]) begin
        open_nxt = 1'b0;
        hc_nxt   = 1'b0;
      end
    end

    if (full) begin
      led_nxt = 1'b1;
    end else if (!open_nxt) begin
      led_nxt = 1'b0;
    end else if ((now_ms - tog_r) >= flash_ms) begin
      tog_nxt = now_ms;
      led_nxt = !led_r;
    end
  end

  // Status record for this tick.
  always_comb begin
    res_nxt.bay1_light = bay1.occ ? (bay1.over ? pbgc_pkg::LIGHT_YELLOW : pbgc_pkg::LIGHT_RED)
                                  : pbgc_pkg::LIGHT_GREEN;
    res_nxt.bay2_light = bay2.occ ? (bay2.over ? pbgc_pkg::LIGHT_YELLOW : pbgc_pkg::LIGHT_RED)
                                  : pbgc_pkg::LIGHT_GREEN;
    res_nxt.gate_open     = open_nxt;
    res_nxt.gate_led      = led_nxt;
    res_nxt.entry_pressed = entry_comm;
    res_nxt.exit_pressed  = exit_comm;

    if (open_nxt) begin
      res_nxt.gate_state = hc_nxt ? pbgc_pkg::GS_HOLD
                                  : (obe_nxt ? pbgc_pkg::GS_OPEN_EXIT : pbgc_pkg::GS_OPEN_ENTRY);
    end else begin
      res_nxt.gate_state = full ? pbgc_pkg::GS_LOCKED : pbgc_pkg::GS_CLOSED;
    end

    if (refl_nxt) begin
      res_nxt.alert_code = pbgc_pkg::AL_REFUSED;
    end else if (bay1.over && bay2.over) begin
      res_nxt.alert_code = pbgc_pkg::AL_BOTH_OVER;
    end else if (bay1.over) begin
      res_nxt.alert_code = pbgc_pkg::AL_BAY1_OVER;
    end else if (bay2.over) begin
      res_nxt.alert_code = pbgc_pkg::AL_BAY2_OVER;
    end else if (full) begin
      res_nxt.alert_code = pbgc_pkg::AL_FULL;
    end else begin
      res_nxt.alert_code = pbgc_pkg::AL_NONE;
    end

    res_nxt.free_spaces = 2'd2 - {1'b0, bay1.occ} - {1'b0, bay2.occ};
  end

  // Gate and LED state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      obe_r  <= 1'b0;
      hc_r   <= 1'b0;
      dl_r   <= '0;
      refl_r <= 1'b0;
      led_r  <= 1'b0;
      tog_r  <= '0;
    end else if (load) begin
      open_r <= open_nxt;
      obe_r  <= obe_nxt;
      hc_r   <= hc_nxt;
      dl_r   <= dl_nxt;
      refl_r <= refl_nxt;
      led_r  <= led_nxt;
      tog_r  <= tog_nxt;
    end
  end

  // First pipeline stage of the status record.
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/parking_bay_and_gate_controller.sv
// ----------------------------------------------------------------------------
// Parking bay and gate controller
// Usage:
//   in_ch carries one sample tick (six echoes, two plate pressures, now_ms);
//   out_ch returns one status record per tick, in order. cfg_ch writes the
//   eight registers by index and is always ready; write only while idle.
//   Two bay lanes and two plate lanes work side by side on each tick, and
//   the gate stage merges their findings and updates the gate state.
//   From transfer on in_ch to valid on out_ch, the lanes and gate stage
//   fill the first register, and the bay seconds reciprocal multiply
//   feeds the output register.
//   Throughput is one tick per cycle while out_ch does not stall; the
//   lanes and gate stage update their state on each accepted tick.
//   When out_ch stalls, the output register holds its record and one more
//   tick is still taken into the first stage; in_ch.ready then drops.
//   Synchronous reset (rst_n low) restores the register defaults, frees
//   both bays, closes the gate and empties the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
`include "parking_bay_and_gate_controller_macros.svh"

module parking_bay_and_gate_controller (
  input  wire logic clk,
  input  wire logic rst_n,
  pbgc_in_if.sink   in_ch,
  pbgc_out_if.source out_ch,
  pbgc_cfg_if.sink  cfg_ch
);

  logic [14:0]        near_r;
  logic [31:0]        overstay_r;
  logic signed [15:0] thr_r;
  logic [31:0]        deb_r;
  logic [31:0]        hold_r;
  logic [31:0]        flash_r;
  logic signed [15:0] ebase_r;
  logic signed [15:0] xbase_r;

  logic                 s1_valid_r;
  logic                 out_valid_r;
  logic                 out_adv;
  logic                 in_rdy;
  logic                 in_acc;
  pbgc_pkg::bay_stat_t  bay1_stat;
  pbgc_pkg::bay_stat_t  bay2_stat;
  logic [22:0]          bay1_secs;
  logic [22:0]          bay2_secs;
  logic                 entry_comm;
  logic                 exit_comm;
  pbgc_pkg::merge_res_t s1_res;
  pbgc_pkg::merge_res_t out_res_r;
  logic [22:0]          out_secs1_r;
  logic [22:0]          out_secs2_r;
  logic                 out_open_st;
  logic                 out_full;
  logic                 out_bay1_free;

  // Configuration registers.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_r     <= pbgc_pkg::RST_NEAR_ECHO;
      overstay_r <= pbgc_pkg::RST_OVERSTAY;
      thr_r      <= pbgc_pkg::RST_THRESHOLD;
      deb_r      <= pbgc_pkg::RST_DEBOUNCE;
      hold_r     <= pbgc_pkg::RST_HOLD;
      flash_r    <= pbgc_pkg::RST_FLASH;
      ebase_r    <= pbgc_pkg::RST_BASELINE;
      xbase_r    <= pbgc_pkg::RST_BASELINE;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.idx)
        pbgc_pkg::CFG_NEAR_ECHO:  near_r     <= cfg_ch.data[14:0];
        pbgc_pkg::CFG_OVERSTAY:   overstay_r <= cfg_ch.data;
        pbgc_pkg::CFG_THRESHOLD:  thr_r      <= cfg_ch.data[15:0];
        pbgc_pkg::CFG_DEBOUNCE:   deb_r      <= cfg_ch.data;
        pbgc_pkg::CFG_HOLD:       hold_r     <= cfg_ch.data;
        pbgc_pkg::CFG_FLASH:      flash_r    <= cfg_ch.data;
        pbgc_pkg::CFG_ENTRY_BASE: ebase_r    <= cfg_ch.data[15:0];
        pbgc_pkg::CFG_EXIT_BASE:  xbase_r    <= cfg_ch.data[15:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control.
  assign out_adv     = !out_valid_r || out_ch.ready;
  assign in_rdy      = !s1_valid_r || out_adv;
  assign in_ch.ready = in_rdy;
  assign in_acc      = in_ch.valid && in_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_rdy) begin
        s1_valid_r <= in_ch.valid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Bay lanes.
  pbgc_bay_lane u_bay1 (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (in_acc),
    .top_echo    (in_ch.bay1_top_echo),
    .left_echo   (in_ch.bay1_left_echo),
    .right_echo  (in_ch.bay1_right_echo),
    .near_us     (near_r),
    .stay_limit  (overstay_r),
    .now_ms      (in_ch.now_ms),
    .stat        (bay1_stat),
    .secs        (bay1_secs)
  );

  pbgc_bay_lane u_bay2 (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (in_acc),
    .top_echo    (in_ch.bay2_top_echo),
    .left_echo   (in_ch.bay2_left_echo),
    .right_echo  (in_ch.bay2_right_echo),
    .near_us     (near_r),
    .stay_limit  (overstay_r),
    .now_ms      (in_ch.now_ms),
    .stat        (bay2_stat),
    .secs        (bay2_secs)
  );

  // Plate lanes.
  pbgc_plate_lane u_entry (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (in_acc),
    .pressure    (in_ch.entry_pressure),
    .baseline    (ebase_r),
    .threshold   (thr_r),
    .debounce_ms (deb_r),
    .now_ms      (in_ch.now_ms),
    .committed   (entry_comm)
  );

  pbgc_plate_lane u_exit (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (in_acc),
    .pressure    (in_ch.exit_pressure),
    .baseline    (xbase_r),
    .threshold   (thr_r),
    .debounce_ms (deb_r),
    .now_ms      (in_ch.now_ms),
    .committed   (exit_comm)
  );

  // Merging stage.
  pbgc_gate_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_acc),
    .bay1       (bay1_stat),
    .bay2       (bay2_stat),
    .entry_comm (entry_comm),
    .exit_comm  (exit_comm),
    .hold_ms    (hold_r),
    .flash_ms   (flash_r),
    .now_ms     (in_ch.now_ms),
    .res_r      (s1_res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      out_res_r   <= s1_res;
      out_secs1_r <= bay1_secs;
      out_secs2_r <= bay2_secs;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.bay1_light    = out_res_r.bay1_light;
  assign out_ch.bay2_light    = out_res_r.bay2_light;
  assign out_ch.gate_open     = out_res_r.gate_open;
  assign out_ch.gate_led      = out_res_r.gate_led;
  assign out_ch.entry_pressed = out_res_r.entry_pressed;
  assign out_ch.exit_pressed  = out_res_r.exit_pressed;
  assign out_ch.gate_state    = out_res_r.gate_state;
  assign out_ch.alert_code    = out_res_r.alert_code;
  assign out_ch.free_spaces   = out_res_r.free_spaces;
  assign out_ch.bay1_seconds  = out_secs1_r;
  assign out_ch.bay2_seconds  = out_secs2_r;

  // Terms used by the checks below.
  assign out_open_st   = (out_res_r.gate_state == pbgc_pkg::GS_OPEN_ENTRY) ||
                         (out_res_r.gate_state == pbgc_pkg::GS_OPEN_EXIT) ||
                         (out_res_r.gate_state == pbgc_pkg::GS_HOLD);
  assign out_full      = out_res_r.free_spaces == 2'd0;
  assign out_bay1_free = out_res_r.bay1_light == pbgc_pkg::LIGHT_GREEN;

  // Checks.
  `PBGC_ASSERT_NEXT(a_accept_fills_s1, in_acc, s1_valid_r, "accepted tick not in first stage")
  `PBGC_ASSERT_NEXT(a_s1_held_on_stall, s1_valid_r && !out_adv, s1_valid_r, "stalled tick lost")
  `PBGC_ASSERT_SAME(a_open_state, out_valid_r && out_res_r.gate_open, out_open_st, "open, closed")
  `PBGC_ASSERT_SAME(a_full_led, out_valid_r && out_full, out_res_r.gate_led, "full lot, LED off")
  `PBGC_ASSERT_SAME(a_free_bay1_secs, out_valid_r && out_bay1_free, out_secs1_r == '0, "free secs")

endmodule

`default_nettype wire

FILE: dv/parking_bay_and_gate_controller_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Parking bay and gate controller checker
// Watches the sample, status and register channels, keeps its own model of
// the bays, plates and gate, and compares every status record with the
// prediction made when its sample tick was taken.
// ----------------------------------------------------------------------------

module parking_bay_and_gate_controller_checker (
  input  logic        clk,
  input  logic        rst_n,
  pbgc_in_if          in_mon,
  pbgc_out_if         out_mon,
  pbgc_cfg_if         cfg_mon,
  output int unsigned fail_count,
  output int unsigned n_pending,
  output int unsigned n_checked
);

  localparam int PLATE_ENTRY = 0;
  localparam int PLATE_EXIT  = 1;

  // One status record as it appears on the status channel.
  typedef struct packed {
    logic [1:0]                  bay1_light;
    logic [1:0]                  bay2_light;
    logic                        gate_open;
    logic                        gate_led;
    logic                        entry_pressed;
    logic                        exit_pressed;
    logic [2:0]                  gate_state;
    logic [2:0]                  alert_code;
    logic [1:0]                  free_spaces;
    logic [pbgc_pkg::SECS_W-1:0] bay1_seconds;
    logic [pbgc_pkg::SECS_W-1:0] bay2_seconds;
  } status_t;

  // Register copies.
  logic [pbgc_pkg::ECHO_W-1:0]         near_lim;
  logic [pbgc_pkg::TIME_W-1:0]         overstay_lim;
  logic [pbgc_pkg::TIME_W-1:0]         debounce_lim;
  logic [pbgc_pkg::TIME_W-1:0]         hold_lim;
  logic [pbgc_pkg::TIME_W-1:0]         flash_lim;
  logic signed [pbgc_pkg::PRESS_W-1:0] press_thr;
  logic signed [pbgc_pkg::PRESS_W-1:0] entry_base;
  logic signed [pbgc_pkg::PRESS_W-1:0] exit_base;

  // Lot state.
  logic [pbgc_pkg::TIME_W-1:0] bay_since [2];
  logic                        bay_held [2];
  logic                        plate_cand [2];
  logic [pbgc_pkg::TIME_W-1:0] plate_cand_ms [2];
  logic                        plate_down [2];
  logic                        gate_up;
  logic                        exit_opened;
  logic                        hold_run;
  logic [pbgc_pkg::TIME_W-1:0] hold_deadline;
  logic                        refused;
  logic                        led_on;
  logic [pbgc_pkg::TIME_W-1:0] led_flip_ms;

  // Status records still owed by the block, oldest first.
  status_t owed_status [$];

  // A sensor sees a car when it echoes at all and no later than the limit.
  function automatic logic is_near(input logic [pbgc_pkg::ECHO_W-1:0] echo);
    return (echo != '0) && (echo <= near_lim);
  endfunction

  // The plate delta wraps to 16 bits before the signed threshold compare.
  function automatic logic plate_hot(input logic signed [pbgc_pkg::PRESS_W-1:0] raw,
                                     input logic signed [pbgc_pkg::PRESS_W-1:0] base);
    logic signed [pbgc_pkg::PRESS_W-1:0] delta;
    delta = raw - base;
    return delta > press_thr;
  endfunction

  // Updates the lot model with one sample tick and returns its status.
  function automatic status_t advance_lot(
    input logic [pbgc_pkg::ECHO_W-1:0]         e1t, e1l, e1r, e2t, e2l, e2r,
    input logic signed [pbgc_pkg::PRESS_W-1:0] entry_raw, exit_raw,
    input logic [pbgc_pkg::TIME_W-1:0]         now
  );
    status_t                     st;
    logic                        occ [2];
    logic                        over [2];
    logic                        hot [2];
    logic [1:0]                  light [2];
    logic [pbgc_pkg::TIME_W-1:0] secs [2];
    logic [pbgc_pkg::TIME_W-1:0] span;
    logic                        full;
    logic                        still_down;
    int                          i;

    occ[0] = is_near(e1t) && is_near(e1l) && is_near(e1r);
    occ[1] = is_near(e2t) && is_near(e2l) && is_near(e2r);
    full   = occ[0] && occ[1];

    // Bays: occupancy start, overstay and whole seconds.
    for (i = 0; i < 2; i++) begin
      over[i]  = 1'b0;
      secs[i]  = '0;
      light[i] = pbgc_pkg::LIGHT_GREEN;
      if (!occ[i]) begin
        bay_held[i]  = 1'b0;
        bay_since[i] = '0;
      end else begin
        if (!bay_held[i]) begin
          bay_held[i]  = 1'b1;
          bay_since[i] = now;
        end
        span     = now - bay_since[i];
        over[i]  = span >= overstay_lim;
        secs[i]  = span / 32'd1000;
        light[i] = over[i] ? pbgc_pkg::LIGHT_YELLOW : pbgc_pkg::LIGHT_RED;
      end
    end

    // Plates: a raw change restarts the debounce window.
    hot[PLATE_ENTRY] = plate_hot(entry_raw, entry_base);
    hot[PLATE_EXIT]  = plate_hot(exit_raw, exit_base);
    for (i = 0; i < 2; i++) begin
      if (hot[i] != plate_cand[i]) begin
        plate_cand[i]    = hot[i];
        plate_cand_ms[i] = now;
      end
      span = now - plate_cand_ms[i];
      if (span >= debounce_lim) plate_down[i] = plate_cand[i];
    end

    // Gate: entry has priority, and a refused entry also blocks the exit.
    if (!gate_up) begin
      if (plate_down[PLATE_ENTRY]) begin
        if (!full) begin
          gate_up     = 1'b1;
          exit_opened = 1'b0;
          hold_run    = 1'b0;
        end else begin
          refused = 1'b1;
        end
      end else begin
        refused = 1'b0;
        if (plate_down[PLATE_EXIT]) begin
          gate_up     = 1'b1;
          exit_opened = 1'b1;
          hold_run    = 1'b0;
        end
      end
    end else begin
      still_down = exit_opened ? plate_down[PLATE_EXIT] : plate_down[PLATE_ENTRY];
      if (!still_down && !hold_run) begin
        hold_run      = 1'b1;
        hold_deadline = now + hold_lim;
      end
      span = now - hold_deadline;
      if (hold_run && !span[pbgc_pkg::TIME_W-1]) begin
        gate_up  = 1'b0;
        hold_run = 1'b0;
      end
    end

    // LED: solid while full, otherwise flashing while the gate is open.
    span = now - led_flip_ms;
    if (full) begin
      led_on = 1'b1;
    end else if (!gate_up) begin
      led_on = 1'b0;
    end else if (span >= flash_lim) begin
      led_flip_ms = now;
      led_on      = !led_on;
    end

    st.bay1_light    = light[0];
    st.bay2_light    = light[1];
    st.gate_open     = gate_up;
    st.gate_led      = led_on;
    st.entry_pressed = plate_down[PLATE_ENTRY];
    st.exit_pressed  = plate_down[PLATE_EXIT];
    if (gate_up) begin
      st.gate_state = hold_run ? pbgc_pkg::GS_HOLD
                               : (exit_opened ? pbgc_pkg::GS_OPEN_EXIT
                                              : pbgc_pkg::GS_OPEN_ENTRY);
    end else begin
      st.gate_state = full ? pbgc_pkg::GS_LOCKED : pbgc_pkg::GS_CLOSED;
    end
    if (refused) begin
      st.alert_code = pbgc_pkg::AL_REFUSED;
    end else if (over[0] && over[1]) begin
      st.alert_code = pbgc_pkg::AL_BOTH_OVER;
    end else if (over[0]) begin
      st.alert_code = pbgc_pkg::AL_BAY1_OVER;
    end else if (over[1]) begin
      st.alert_code = pbgc_pkg::AL_BAY2_OVER;
    end else if (full) begin
      st.alert_code = pbgc_pkg::AL_FULL;
    end else begin
      st.alert_code = pbgc_pkg::AL_NONE;
    end
    st.free_spaces  = 2'd2 - 2'(occ[0]) - 2'(occ[1]);
    st.bay1_seconds = secs[0][pbgc_pkg::SECS_W-1:0];
    st.bay2_seconds = secs[1][pbgc_pkg::SECS_W-1:0];
    return st;
  endfunction

  // Reports one field that differs from its prediction.
  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // Transfers are sampled at the rising edge, before the drivers update.
  always @(posedge clk) begin
    status_t want;
    if (!rst_n) begin
      near_lim      = pbgc_pkg::RST_NEAR_ECHO;
      overstay_lim  = pbgc_pkg::RST_OVERSTAY;
      press_thr     = pbgc_pkg::RST_THRESHOLD;
      debounce_lim  = pbgc_pkg::RST_DEBOUNCE;
      hold_lim      = pbgc_pkg::RST_HOLD;
      flash_lim     = pbgc_pkg::RST_FLASH;
      entry_base    = pbgc_pkg::RST_BASELINE;
      exit_base     = pbgc_pkg::RST_BASELINE;
      bay_since     = '{default: '0};
      bay_held      = '{default: 1'b0};
      plate_cand    = '{default: 1'b0};
      plate_cand_ms = '{default: '0};
      plate_down    = '{default: 1'b0};
      gate_up       = 1'b0;
      exit_opened   = 1'b0;
      hold_run      = 1'b0;
      hold_deadline = '0;
      refused       = 1'b0;
      led_on        = 1'b0;
      led_flip_ms   = '0;
      owed_status.delete();
      n_pending <= 0;
    end else begin
      // Register writes.
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.idx)
          pbgc_pkg::CFG_NEAR_ECHO:  near_lim     = cfg_mon.data[pbgc_pkg::ECHO_W-1:0];
          pbgc_pkg::CFG_OVERSTAY:   overstay_lim = cfg_mon.data;
          pbgc_pkg::CFG_THRESHOLD:  press_thr    = cfg_mon.data[pbgc_pkg::PRESS_W-1:0];
          pbgc_pkg::CFG_DEBOUNCE:   debounce_lim = cfg_mon.data;
          pbgc_pkg::CFG_HOLD:       hold_lim     = cfg_mon.data;
          pbgc_pkg::CFG_FLASH:      flash_lim    = cfg_mon.data;
          pbgc_pkg::CFG_ENTRY_BASE: entry_base   = cfg_mon.data[pbgc_pkg::PRESS_W-1:0];
          pbgc_pkg::CFG_EXIT_BASE:  exit_base    = cfg_mon.data[pbgc_pkg::PRESS_W-1:0];
          default: ;
        endcase
      end

      // Each sample transfer owes exactly one status record.
      if (in_mon.valid && in_mon.ready) begin
        owed_status.push_back(advance_lot(
          in_mon.bay1_top_echo, in_mon.bay1_left_echo, in_mon.bay1_right_echo,
          in_mon.bay2_top_echo, in_mon.bay2_left_echo, in_mon.bay2_right_echo,
          in_mon.entry_pressure, in_mon.exit_pressure, in_mon.now_ms));
      end

      // Status transfers are matched in order.
      if (out_mon.valid && out_mon.ready) begin
        if (owed_status.size() == 0) begin
          fail_count++;
          $display("%0t: status record with none expected, expected nothing, actual %h",
                   $time, out_mon.gate_state);
        end else begin
          want = owed_status.pop_front();
          n_checked++;
          check_field("bay1_light", want.bay1_light, out_mon.bay1_light);
          check_field("bay2_light", want.bay2_light, out_mon.bay2_light);
          check_field("gate_open", want.gate_open, out_mon.gate_open);
          check_field("gate_led", want.gate_led, out_mon.gate_led);
          check_field("entry_pressed", want.entry_pressed, out_mon.entry_pressed);
          check_field("exit_pressed", want.exit_pressed, out_mon.exit_pressed);
          check_field("gate_state", want.gate_state, out_mon.gate_state);
          check_field("alert_code", want.alert_code, out_mon.alert_code);
          check_field("free_spaces", want.free_spaces, out_mon.free_spaces);
          check_field("bay1_seconds", want.bay1_seconds, out_mon.bay1_seconds);
          check_field("bay2_seconds", want.bay2_seconds, out_mon.bay2_seconds);
        end
      end
      n_pending <= owed_status.size();
    end
  end

endmodule

FILE: dv/parking_bay_and_gate_controller_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Parking bay and gate controller testbench
// Drives a short directed walk through the lot, then phases of generated
// traffic (cars arriving and leaving, plates held and released, time moving
// forward and wrapping) under several register settings, with random gaps
// and stalls on both channels. The checker predicts and compares.
// ----------------------------------------------------------------------------

module parking_bay_and_gate_controller_tb;

  localparam int LIMIT_CYCLES = 100000;

  logic        clk;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned n_pending;
  int unsigned n_checked;
  int unsigned ticks_sent;
  int unsigned drains;
  int unsigned cycle_count;
  int          sink_wait;
  bit          sink_stalls;
  bit          src_gappy;

  // Register values currently loaded, used to shape well-formed samples.
  logic [pbgc_pkg::ECHO_W-1:0]         cur_near;
  logic signed [pbgc_pkg::PRESS_W-1:0] cur_thr;
  logic signed [pbgc_pkg::PRESS_W-1:0] cur_entry_base;
  logic signed [pbgc_pkg::PRESS_W-1:0] cur_exit_base;

  // Generated lot: which bays hold a car, which plates are stood on.
  logic [pbgc_pkg::TIME_W-1:0] lot_ms;
  bit                          bay_taken [2];
  bit                          entry_on;
  bit                          exit_on;

  pbgc_in_if  in_ch ();
  pbgc_out_if out_ch ();
  pbgc_cfg_if cfg_ch ();

  parking_bay_and_gate_controller DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  parking_bay_and_gate_controller_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_mon    (cfg_ch),
    .fail_count (fail_count),
    .n_pending  (n_pending),
    .n_checked  (n_checked)
  );

  // 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Status sink: random stalls after each transfer, in stretches with and
  // without them.
  always @(posedge clk) begin
    int stall;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_wait    <= 0;
    end else if (!out_ch.ready) begin
      if (sink_wait == 0) out_ch.ready <= 1'b1;
      else sink_wait <= sink_wait - 1;
    end else if (out_ch.valid) begin
      if ($urandom_range(0, 39) == 0) sink_stalls = !sink_stalls;
      stall = sink_stalls ? $urandom_range(0, 4) : 0;
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        sink_wait    <= stall - 1;
      end
    end
  end

  // One register write; valid stays high for a following write.
  task automatic write_reg(input logic [pbgc_pkg::CIDX_W-1:0] idx, input logic [31:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.idx   <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // Loads all eight registers; only called while the lot is drained.
  task automatic load_settings(
    input logic [pbgc_pkg::ECHO_W-1:0]         near,
    input logic [pbgc_pkg::TIME_W-1:0]         overstay,
    input logic signed [pbgc_pkg::PRESS_W-1:0] thr,
    input logic [pbgc_pkg::TIME_W-1:0]         debounce,
    input logic [pbgc_pkg::TIME_W-1:0]         hold,
    input logic [pbgc_pkg::TIME_W-1:0]         flash,
    input logic signed [pbgc_pkg::PRESS_W-1:0] entry_base,
    input logic signed [pbgc_pkg::PRESS_W-1:0] exit_base
  );
    write_reg(pbgc_pkg::CFG_NEAR_ECHO, 32'(near));
    write_reg(pbgc_pkg::CFG_OVERSTAY, overstay);
    write_reg(pbgc_pkg::CFG_THRESHOLD, 32'(thr));
    write_reg(pbgc_pkg::CFG_DEBOUNCE, debounce);
    write_reg(pbgc_pkg::CFG_HOLD, hold);
    write_reg(pbgc_pkg::CFG_FLASH, flash);
    write_reg(pbgc_pkg::CFG_ENTRY_BASE, 32'(entry_base));
    write_reg(pbgc_pkg::CFG_EXIT_BASE, 32'(exit_base));
    cfg_ch.valid   <= 1'b0;
    cur_near       = near;
    cur_thr        = thr;
    cur_entry_base = entry_base;
    cur_exit_base  = exit_base;
  endtask

  // One sample transfer, after a random gap; valid is only lowered when a
  // gap follows, so it never falls and rises in the same step.
  task automatic send_tick(
    input logic [pbgc_pkg::ECHO_W-1:0]  b1t, b1l, b1r, b2t, b2l, b2r,
    input logic [pbgc_pkg::PRESS_W-1:0] entry_p, exit_p,
    input logic [pbgc_pkg::TIME_W-1:0]  stamp
  );
    int gap;
    if ($urandom_range(0, 39) == 0) src_gappy = !src_gappy;
    gap = src_gappy ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.bay1_top_echo   <= b1t;
    in_ch.bay1_left_echo  <= b1l;
    in_ch.bay1_right_echo <= b1r;
    in_ch.bay2_top_echo   <= b2t;
    in_ch.bay2_left_echo  <= b2l;
    in_ch.bay2_right_echo <= b2r;
    in_ch.entry_pressure  <= entry_p;
    in_ch.exit_pressure   <= exit_p;
    in_ch.now_ms          <= stamp;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    ticks_sent++;
  endtask

  // Holds the sender until every owed status record has come back.
  task automatic drain_lot();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    drains++;
  endtask

  // Echo for one sensor: near the car, or nothing / something far away.
  function automatic logic [pbgc_pkg::ECHO_W-1:0] echo_word(input bit close);
    if (close) begin
      return (cur_near == '0) ? '0 : pbgc_pkg::ECHO_W'($urandom_range(1, cur_near));
    end
    if ($urandom_range(0, 1) == 0 || cur_near == '1) return '0;
    return pbgc_pkg::ECHO_W'($urandom_range(int'(cur_near) + 1, 32767));
  endfunction

  // Raw plate word above or not above the threshold, often at the boundary.
  function automatic logic [pbgc_pkg::PRESS_W-1:0] plate_word(
    input bit on,
    input logic signed [pbgc_pkg::PRESS_W-1:0] base
  );
    int lo;
    int delta;
    if (on) begin
      if (cur_thr == 16'sh7fff) return pbgc_pkg::PRESS_W'($urandom);
      lo    = int'(cur_thr) + 1;
      delta = ($urandom_range(0, 3) == 0) ? lo : lo + int'($urandom_range(0, 32767 - lo));
    end else if ($urandom_range(0, 3) == 0) begin
      delta = int'(cur_thr);
    end else begin
      delta = -32768 + int'($urandom_range(0, int'(cur_thr) + 32768));
    end
    return pbgc_pkg::PRESS_W'(int'(base) + delta);
  endfunction

  // One generated tick: time moves on, cars and feet come and go, and now
  // and then the whole sample is noise.
  task automatic send_world_tick();
    logic [pbgc_pkg::ECHO_W-1:0]  echo [6];
    logic [pbgc_pkg::PRESS_W-1:0] entry_p;
    logic [pbgc_pkg::PRESS_W-1:0] exit_p;
    int                           roll;
    int                           pick;
    int                           b;
    int                           s;

    roll = $urandom_range(0, 99);
    if (roll < 2) lot_ms = $urandom;
    else if (roll < 8) lot_ms = lot_ms + $urandom_range(0, 20000);
    else lot_ms = lot_ms + $urandom_range(0, 300);

    for (b = 0; b < 2; b++) begin
      if ($urandom_range(0, 29) == 0) bay_taken[b] = !bay_taken[b];
    end
    if ($urandom_range(0, 5) == 0) entry_on = !entry_on;
    if ($urandom_range(0, 5) == 0) exit_on = !exit_on;

    if ($urandom_range(0, 9) == 0) begin
      for (s = 0; s < 6; s++) echo[s] = pbgc_pkg::ECHO_W'($urandom_range(0, 32767));
      entry_p = pbgc_pkg::PRESS_W'($urandom);
      exit_p  = pbgc_pkg::PRESS_W'($urandom);
    end else begin
      for (b = 0; b < 2; b++) begin
        // A free bay may still show one or two near sensors.
        pick = bay_taken[b] ? 7 : $urandom_range(0, 6);
        for (s = 0; s < 3; s++) echo[3 * b + s] = echo_word(pick[s]);
      end
      entry_p = plate_word(entry_on, cur_entry_base);
      exit_p  = plate_word(exit_on, cur_exit_base);
    end
    send_tick(echo[0], echo[1], echo[2], echo[3], echo[4], echo[5],
              entry_p, exit_p, lot_ms);
  endtask

  // Stimulus and verdict.
  initial begin
    int phase;
    int n_items;
    int k;

    rst_n                 <= 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.bay1_top_echo   <= '0;
    in_ch.bay1_left_echo  <= '0;
    in_ch.bay1_right_echo <= '0;
    in_ch.bay2_top_echo   <= '0;
    in_ch.bay2_left_echo  <= '0;
    in_ch.bay2_right_echo <= '0;
    in_ch.entry_pressure  <= '0;
    in_ch.exit_pressure   <= '0;
    in_ch.now_ms          <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.idx            <= pbgc_pkg::CFG_NEAR_ECHO;
    cfg_ch.data           <= '0;
    cur_near              = pbgc_pkg::RST_NEAR_ECHO;
    cur_thr               = pbgc_pkg::RST_THRESHOLD;
    cur_entry_base        = pbgc_pkg::RST_BASELINE;
    cur_exit_base         = pbgc_pkg::RST_BASELINE;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed walk under the reset values.
    // Empty lot, then bay 1 taken with the clock at zero.
    send_tick(0, 0, 0, 0, 0, 0, 16'h0000, 16'h0000, 32'd0);
    send_tick(1, 1, 1, 0, 0, 0, 16'h0000, 16'h0000, 32'd0);
    // Echoes right at the near limit and one past it; extreme plate words.
    send_tick(2320, 2320, 2320, 2321, 1, 1, 16'h8000, 16'h7fff, 32'd150);
    send_tick(5, 6, 7, 15'h7fff, 15'h7fff, 15'h7fff, 16'h7fff, 16'h7fff, 32'd300);
    // Lot full with both plates down: entry is refused and blocks the exit.
    send_tick(5, 6, 7, 100, 200, 300, 16'h7fff, 16'h7fff, 32'd700);
    // A space frees up and the held entry opens the gate.
    send_tick(5, 6, 7, 100, 200, 0, 16'h7fff, 16'h7fff, 32'd900);
    // Entry released, release commits, hold runs out.
    send_tick(5, 6, 7, 0, 0, 0, 16'h0000, 16'h7fff, 32'd1000);
    send_tick(5, 6, 7, 0, 0, 0, 16'h0000, 16'h7fff, 32'd1300);
    send_tick(5, 6, 7, 0, 0, 0, 16'd120, 16'h7fff, 32'd7300);
    // Just above the threshold; the exit plate reopens the gate.
    send_tick(5, 6, 7, 0, 0, 0, 16'd121, 16'h7fff, 32'd7450);
    // Bay 1 reaches overstay, then its longest time, then the clock wraps.
    send_tick(5, 6, 7, 0, 0, 0, 16'd121, 16'h8000, 32'd10000);
    send_tick(5, 6, 7, 0, 0, 0, 16'd121, 16'h8000, 32'hffff_ff00);
    send_tick(5, 6, 7, 9, 9, 9, 16'd121, 16'h8000, 32'h0000_0100);
    // Both bays past overstay.
    send_tick(5, 6, 7, 9, 9, 9, 16'h0000, 16'h0000, 32'h0000_2810);
    send_tick(5, 6, 7, 9, 9, 9, 16'h0000, 16'h0000, 32'h0000_4000);
    drain_lot();

    // Generated traffic under reset, extreme and random settings.
    for (phase = 0; phase < 7; phase++) begin
      case (phase)
        0: begin
          load_settings(pbgc_pkg::RST_NEAR_ECHO, pbgc_pkg::RST_OVERSTAY,
                        pbgc_pkg::RST_THRESHOLD, pbgc_pkg::RST_DEBOUNCE,
                        pbgc_pkg::RST_HOLD, pbgc_pkg::RST_FLASH,
                        pbgc_pkg::RST_BASELINE, pbgc_pkg::RST_BASELINE);
        end
        1: begin
          load_settings(15'h7fff, 32'd0, 16'sh8000, 32'd0, 32'd0, 32'd0,
                        16'sh8000, 16'sh7fff);
        end
        2: begin
          load_settings(15'd25000, 32'hffff_ffff, 16'sh7fff, 32'hffff_ffff,
                        32'h8000_0000, 32'hffff_ffff, 16'sh7fff, 16'sh8000);
        end
        3: begin
          load_settings(15'd0, 32'd1, 16'sd0, 32'd1, 32'hffff_ffff, 32'd1,
                        16'sd0, 16'sd0);
        end
        default: begin
          // Phase 5 uses hold times of 2^31 or more; all but 2^31 itself close at once.
          load_settings(pbgc_pkg::ECHO_W'($urandom_range(500, 25000)),
                        $urandom_range(0, 30000),
                        pbgc_pkg::PRESS_W'(int'($urandom_range(0, 2000)) - 1000),
                        $urandom_range(0, 800),
                        (phase == 5) ? ($urandom | 32'h8000_0000) : $urandom_range(0, 8000),
                        $urandom_range(0, 600),
                        pbgc_pkg::PRESS_W'($urandom),
                        pbgc_pkg::PRESS_W'($urandom));
        end
      endcase
      lot_ms  = (phase == 4) ? 32'hffff_f000 : $urandom;
      n_items = (phase == 2 || phase == 3) ? 100 : 160;
      for (k = 0; k < n_items; k++) begin
        send_world_tick();
        if ($urandom_range(0, 59) == 0) drain_lot();
      end
      drain_lot();
    end

    $display("Sent %0d sample ticks under reset, extreme and random register settings;",
             ticks_sent);
    $display("checked %0d status records, with the sender held for %0d drains.",
             n_checked, drains);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
